>>> design/otgvl_pkg.sv
// Shared types, constants and register indexes for the velocity limiter.
package otgvl_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  localparam int LIMIT_W  = 31;
  localparam int PERIOD_W = 25;
  localparam int RATE_W   = 20;

  // Square root: 64-bit radicand, one root bit per cell.
  localparam int RAD_W      = 64;
  localparam int ROOT_W     = 32;
  localparam int REM_W      = 34;
  localparam int SQRT_CELLS = ROOT_W;

  localparam logic [LIMIT_W-1:0]  ACCEL_RESET  = 31'd65536;
  localparam logic [LIMIT_W-1:0]  SPEED_RESET  = 31'd32768;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 25'd16777;
  localparam logic [RATE_W-1:0]   RATE_RESET   = 20'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEL_JOINT = 3'd0,
    REG_SPEED_JOINT = 3'd1,
    REG_ACCEL_CART  = 3'd2,
    REG_SPEED_CART  = 3'd3,
    REG_PERIOD      = 3'd4,
    REG_RATE        = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    LIM_ERR_RATE = 2'd0,
    LIM_ACCEL    = 2'd1,
    LIM_VMAX     = 2'd2,
    LIM_BRAKE    = 2'd3
  } limit_e;

  typedef struct packed {
    logic [LIMIT_W-1:0]  accel_joint;
    logic [LIMIT_W-1:0]  speed_joint;
    logic [LIMIT_W-1:0]  accel_cart;
    logic [LIMIT_W-1:0]  speed_cart;
    logic [PERIOD_W-1:0] period;
    logic [RATE_W-1:0]   rate;
  } limits_t;

  // Travels alongside the root computation.
  typedef struct packed {
    logic [2:0]         tag;
    logic               neg;
    logic signed [31:0] best;
    limit_e             code;
  } side_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    side_t             side;
  } sqrt_slot_t;

endpackage

>>> design/otgvl_channels.sv
// Channel interfaces for axis samples and planned results.
interface otgvl_sample_if;
  logic               valid;
  logic               ready;
  logic               space;
  logic [2:0]         axis_tag;
  logic signed [31:0] velocity_now;
  logic signed [31:0] position_error;

  modport source(output valid, space, axis_tag, velocity_now, position_error, input ready);
  modport sink(input valid, space, axis_tag, velocity_now, position_error, output ready);
endinterface

interface otgvl_result_if;
  logic               valid;
  logic               ready;
  logic [2:0]         axis_out;
  logic signed [31:0] planned_velocity;
  logic [1:0]         limit_code;

  modport source(output valid, axis_out, planned_velocity, limit_code, input ready);
  modport sink(input valid, axis_out, planned_velocity, limit_code, output ready);
endinterface

>>> design/otgvl_front.sv
// Front stages: operand prep, products, and the first three bounds reduced to one.
module otgvl_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic                    space,
  input  logic [2:0]              axis_tag,
  input  logic signed [31:0]      velocity_now,
  input  logic signed [31:0]      position_error,
  input  otgvl_pkg::limits_t      lim,
  output logic                    out_valid,
  output otgvl_pkg::sqrt_slot_t   out_slot
);

  // stage 0: magnitudes and limit selection
  logic                             v0;
  logic [2:0]                       tag0;
  logic                             neg0;
  logic [31:0]                      mag0;
  logic signed [32:0]               along0;
  logic [otgvl_pkg::LIMIT_W-1:0]    amax0;
  logic [otgvl_pkg::LIMIT_W-1:0]    vmax0;

  // stage 1: products
  logic                             v1;
  logic [2:0]                       tag1;
  logic                             neg1;
  logic signed [32:0]               along1;
  logic [otgvl_pkg::LIMIT_W-1:0]    vmax1;
  logic [51:0]                      b0_1;
  logic [31:0]                      step1;
  logic [otgvl_pkg::RAD_W-1:0]      rad1;

  // stage 2: acceleration bound
  logic                             v2;
  logic [2:0]                       tag2;
  logic                             neg2;
  logic [otgvl_pkg::LIMIT_W-1:0]    vmax2;
  logic [51:0]                      b0_2;
  logic signed [33:0]               b1_2;
  logic [otgvl_pkg::RAD_W-1:0]      rad2;

  // stage 3: min of error-rate and acceleration bounds
  logic                             v3;
  logic [2:0]                       tag3;
  logic                             neg3;
  logic [otgvl_pkg::LIMIT_W-1:0]    vmax3;
  logic signed [52:0]               best3;
  otgvl_pkg::limit_e                code3;
  logic [otgvl_pkg::RAD_W-1:0]      rad3;

  logic               neg_c;
  logic [31:0]        mag_c;
  logic signed [32:0] vel_ext;
  logic [55:0]        step_prod;
  logic [62:0]        brake_prod;
  logic signed [52:0] b0_s;
  logic signed [52:0] b1_s;
  logic signed [52:0] vmax_s;

  always_comb begin
    neg_c   = position_error[31];
    mag_c   = neg_c ? 32'(-position_error) : 32'(position_error);
    vel_ext = 33'(velocity_now);
    step_prod  = {25'b0, amax0} * {31'b0, lim.period};
    brake_prod = {32'b0, amax0} * {31'b0, mag0};
    b0_s   = $signed({1'b0, b0_2});
    b1_s   = 53'(b1_2);
    vmax_s = $signed({22'b0, vmax3});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag0   <= axis_tag;
      neg0   <= neg_c;
      mag0   <= mag_c;
      along0 <= neg_c ? -vel_ext : vel_ext;
      amax0  <= space ? lim.accel_cart : lim.accel_joint;
      vmax0  <= space ? lim.speed_cart : lim.speed_joint;

      tag1   <= tag0;
      neg1   <= neg0;
      along1 <= along0;
      vmax1  <= vmax0;
      b0_1   <= {20'b0, mag0} * {32'b0, lim.rate};
      step1  <= step_prod[55:24];
      rad1   <= {1'b0, brake_prod} << 1;

      tag2  <= tag1;
      neg2  <= neg1;
      vmax2 <= vmax1;
      b0_2  <= b0_1;
      b1_2  <= 34'(along1) + $signed({2'b0, step1});
      rad2  <= rad1;

      tag3  <= tag2;
      neg3  <= neg2;
      vmax3 <= vmax2;
      rad3  <= rad2;
      if (b0_s > b1_s) begin
        best3 <= b1_s;
        code3 <= otgvl_pkg::LIM_ACCEL;
      end else begin
        best3 <= b0_s;
        code3 <= otgvl_pkg::LIM_ERR_RATE;
      end

      // result fits 32 bits signed: at most vmax, at least -2^31
      out_slot.rad       <= rad3;
      out_slot.rem       <= '0;
      out_slot.root      <= '0;
      out_slot.side.tag  <= tag3;
      out_slot.side.neg  <= neg3;
      if (best3 > vmax_s) begin
        out_slot.side.best <= $signed({1'b0, vmax3});
        out_slot.side.code <= otgvl_pkg::LIM_VMAX;
      end else begin
        out_slot.side.best <= best3[31:0];
        out_slot.side.code <= code3;
      end
    end
  end

endmodule

>>> design/otgvl_sqrt_cell.sv
// One square root cell: takes two radicand bits and settles one root bit.
module otgvl_sqrt_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  otgvl_pkg::sqrt_slot_t in_slot,
  output logic                  out_valid,
  output otgvl_pkg::sqrt_slot_t out_slot
);

  logic [otgvl_pkg::REM_W+1:0] acc;
  logic [otgvl_pkg::REM_W+1:0] trial;
  otgvl_pkg::sqrt_slot_t       slot_next;

  always_comb begin
    acc   = {in_slot.rem, in_slot.rad[otgvl_pkg::RAD_W-1 -: 2]};
    trial = {2'b0, in_slot.root, 2'b01};
    slot_next      = in_slot;
    slot_next.rad  = {in_slot.rad[otgvl_pkg::RAD_W-3:0], 2'b00};
    if (acc >= trial) begin
      slot_next.rem  = otgvl_pkg::REM_W'(acc - trial);
      slot_next.root = {in_slot.root[otgvl_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      // acc < trial, so it already fits the remainder width
      slot_next.rem  = acc[otgvl_pkg::REM_W-1:0];
      slot_next.root = {in_slot.root[otgvl_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_slot <= slot_next;
    end
  end

endmodule

>>> design/otg_velocity_limiter.sv
// Top level of the online trajectory velocity limiter.
//
// One axis sample enters on the sample channel (valid/ready): space, axis
// tag, measured velocity and position error in Q16.16. One result leaves on
// the result channel: the axis tag, the planned velocity (Q16.16, saturated)
// and the code of the winning bound.
// From sample transaction to result valid a sample passes five front stages
// (operands, products, bound reduction), the first loaded at the transaction
// edge, 32 square root cells that each settle one root bit, and one output
// register. A new sample is taken every cycle unless stalled; every stage,
// including each root cell, is a register, so nothing recirculates. Limits,
// servo period and servo rate are written on the cfg port; the user must
// write them while no sample is in flight, as the block does not enforce
// it. Reset loads the default limits and empties the pipeline. When the
// receiver stalls, the output register holds its result; the pipeline
// keeps advancing into empty slots and freezes only once the last cell
// holds a result too, dropping sample.ready until the result is taken.
module otg_velocity_limiter (
  input  logic                                 clk,
  input  logic                                 rst,
  otgvl_sample_if.sink                         sample,
  otgvl_result_if.source                       result,
  input  logic                                 cfg_write,
  input  logic [otgvl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [otgvl_pkg::CFG_DATA_W-1:0]     cfg_data
);

  otgvl_pkg::limits_t    lim;
  logic                  en;
  logic                  out_load;
  logic                  chain_valid [otgvl_pkg::SQRT_CELLS+1];
  otgvl_pkg::sqrt_slot_t chain_slot  [otgvl_pkg::SQRT_CELLS+1];
  logic                  last_valid;
  otgvl_pkg::sqrt_slot_t last_slot;

  logic signed [32:0]    best_ext;
  logic signed [32:0]    root_ext;
  logic signed [32:0]    chosen;
  otgvl_pkg::limit_e     chosen_code;
  logic signed [33:0]    plan;
  logic signed [31:0]    plan_sat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lim.accel_joint <= otgvl_pkg::ACCEL_RESET;
      lim.speed_joint <= otgvl_pkg::SPEED_RESET;
      lim.accel_cart  <= otgvl_pkg::ACCEL_RESET;
      lim.speed_cart  <= otgvl_pkg::SPEED_RESET;
      lim.period      <= otgvl_pkg::PERIOD_RESET;
      lim.rate        <= otgvl_pkg::RATE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        otgvl_pkg::REG_ACCEL_JOINT: lim.accel_joint <= cfg_data;
        otgvl_pkg::REG_SPEED_JOINT: lim.speed_joint <= cfg_data;
        otgvl_pkg::REG_ACCEL_CART:  lim.accel_cart  <= cfg_data;
        otgvl_pkg::REG_SPEED_CART:  lim.speed_cart  <= cfg_data;
        otgvl_pkg::REG_PERIOD:      lim.period      <= cfg_data[otgvl_pkg::PERIOD_W-1:0];
        otgvl_pkg::REG_RATE:        lim.rate        <= cfg_data[otgvl_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // output register takes a result when empty or drained; the pipeline
  // may also move when its last slot is a bubble
  assign out_load     = !result.valid || result.ready;
  assign en           = out_load || !last_valid;
  assign sample.ready = en;

  otgvl_front u_front (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_valid       (sample.valid),
    .space          (sample.space),
    .axis_tag       (sample.axis_tag),
    .velocity_now   (sample.velocity_now),
    .position_error (sample.position_error),
    .lim            (lim),
    .out_valid      (chain_valid[0]),
    .out_slot       (chain_slot[0])
  );

  for (genvar i = 0; i < otgvl_pkg::SQRT_CELLS; i++) begin : g_cell
    otgvl_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (chain_valid[i]),
      .in_slot   (chain_slot[i]),
      .out_valid (chain_valid[i+1]),
      .out_slot  (chain_slot[i+1])
    );
  end

  assign last_valid = chain_valid[otgvl_pkg::SQRT_CELLS];
  assign last_slot  = chain_slot[otgvl_pkg::SQRT_CELLS];

  // braking bound against the best of the other three, then sign and clamp
  always_comb begin
    best_ext = 33'(last_slot.side.best);
    root_ext = $signed({1'b0, last_slot.root});
    if (best_ext > root_ext) begin
      chosen      = root_ext;
      chosen_code = otgvl_pkg::LIM_BRAKE;
    end else begin
      chosen      = best_ext;
      chosen_code = last_slot.side.code;
    end
    plan = last_slot.side.neg ? -34'(chosen) : 34'(chosen);
    if (plan > 34'sh0_7FFF_FFFF) begin
      plan_sat = 32'sh7FFF_FFFF;
    end else if (plan < -34'sh0_8000_0000) begin
      plan_sat = -32'sh8000_0000;
    end else begin
      plan_sat = plan[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= last_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && last_valid) begin
      result.axis_out         <= last_slot.side.tag;
      result.planned_velocity <= plan_sat;
      result.limit_code       <= chosen_code;
    end
  end

  // a full last cell behind a stalled output must block new samples
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready && last_valid |-> !sample.ready)
    else $error("sample accepted while pipeline is full and output stalled");

  // braking bound is never negative, so its result never reaches -2^31
  a_brake_range: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.limit_code == otgvl_pkg::LIM_BRAKE
      |-> result.planned_velocity != -32'sh8000_0000)
    else $error("braking bound produced an out-of-range velocity");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result.valid && !last_valid)
    else $error("pipeline not empty after reset");

endmodule
